// ===== src/rsr_pkg.sv =====
// Shared types and constants of the reverse slice repeater.
package rsr_pkg;

    // Sample and gain widths (Q1.15 samples, unsigned Q1.15 gains).
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_LIMIT = 2'd1;
    localparam logic [15:0] SLICE_LENGTH_RESET = 16'd2205;
    localparam logic [2:0] REPEAT_LIMIT_RESET = 3'd5;

    // Fixed-point constants for the raised-cosine fade-in table.
    localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_LEVEL_W = 3;

    // Where the sample for the gain stage comes from.
    typedef enum logic [1:0]
    {
        SRC_INPUT,
        SRC_RAM,
        SRC_ZERO
    } src_t;

    typedef struct packed
    {
        logic [15:0] slice_length;
        logic [2:0] repeat_limit;
    } cfg_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] value;
        logic [GAIN_W-1:0] gain;
    } q_entry_t;

endpackage

// ===== src/rsr_in_if.sv =====
// Input stream interface: one sample for one channel per transfer.
interface rsr_in_if;
    logic valid;
    logic ready;
    logic channel;
    logic signed [15:0] sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink (input valid, input channel, input sample_in, output ready);
endinterface

// ===== src/rsr_out_if.sv =====
// Output stream interface: one processed sample per transfer.
interface rsr_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

// ===== src/reverse_slice_repeater_top.sv =====
// Reverse slice repeater top level: configuration registers, front, queue and back.
// A result passes the stage register, the queue and the output register before it is presented.
// Throughput: one sample per cycle unless stalled, set by the single write and single read port of the ring.
// The front stalls only when the queue and the stage register ahead of it together hold four samples.
// Reset is asynchronous and active low; it resets all per-channel state and the configuration registers.
// No clearing pass: ring entries not yet written since reset read as zero via a fill mark.
module reverse_slice_repeater_top
    import rsr_pkg::*;
#(
    parameter int RING_DEPTH = 65536,
    parameter int XFADE_LEN = 64,
    parameter int CHANNELS = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    rsr_in_if.sink                 samples,
    rsr_out_if.source              results,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic [Q_LEVEL_W-1:0] q_level;
    logic q_push;
    q_entry_t q_push_entry;
    logic q_pop;
    logic q_head_valid;
    q_entry_t q_head_entry;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slice_length <= SLICE_LENGTH_RESET;
            cfg_reg.repeat_limit <= REPEAT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SLICE_LENGTH: cfg_reg.slice_length <= cfg_data;
                REG_REPEAT_LIMIT: cfg_reg.repeat_limit <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    rsr_front
    #(
        .RING_DEPTH (RING_DEPTH),
        .XFADE_LEN  (XFADE_LEN),
        .CHANNELS   (CHANNELS)
    )
    u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg_reg),
        .q_level (q_level),
        .q_push  (q_push),
        .q_entry (q_push_entry)
    );

    rsr_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .level      (q_level),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    rsr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .results    (results)
    );

endmodule

// ===== src/rsr_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
module rsr_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/rsr_front.sv =====
// Front part: accepts samples, keeps per-channel slice state and the ring, picks the gain.
module rsr_front
    import rsr_pkg::*;
#(
    parameter int RING_DEPTH = 65536,
    parameter int XFADE_LEN = 64,
    parameter int CHANNELS = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rsr_in_if.sink               samples,
    input  cfg_t                 cfg,
    input  logic [Q_LEVEL_W-1:0] q_level,
    output logic                 q_push,
    output q_entry_t             q_entry
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int FI_W = $clog2(XFADE_LEN + 1);
    localparam int FA_W = $clog2(XFADE_LEN);
    localparam int CW = (IDX_W > FI_W) ? IDX_W : FI_W;
    localparam int NCH = (CHANNELS < 2) ? 1 : 2;
    localparam int ADDR_W = $clog2(NCH * RING_DEPTH);
    localparam int SLEN_MAX = RING_DEPTH - 1;

    // Gain tables, worked out at elaboration.
    logic [GAIN_W-1:0] fade_in_rom [XFADE_LEN];
    logic [GAIN_W-1:0] fade_out_rom [XFADE_LEN];

    for (genvar gi = 0; gi < XFADE_LEN; gi++)
    begin : g_rom
        localparam logic [63:0] T = (PI_HALF_Q30 * 64'(gi)) / XFADE_LEN;
        localparam logic [63:0] T2 = (T * T) >> 30;
        localparam logic [63:0] R1 = ONE_Q30 - ((T2 * ONE_Q30) >> 30) / 110;
        localparam logic [63:0] R2 = ONE_Q30 - ((T2 * R1) >> 30) / 72;
        localparam logic [63:0] R3 = ONE_Q30 - ((T2 * R2) >> 30) / 42;
        localparam logic [63:0] R4 = ONE_Q30 - ((T2 * R3) >> 30) / 20;
        localparam logic [63:0] R5 = ONE_Q30 - ((T2 * R4) >> 30) / 6;
        localparam logic [63:0] S = (T * R5) >> 30;
        localparam logic [63:0] W = (S * S) >> 30;
        localparam logic [63:0] G = (W + 64'd16384) >> 15;
        localparam logic [63:0] GC = (G > 64'd32768) ? 64'd32768 : G;
        localparam int FO = ((XFADE_LEN - gi) * 32768) / XFADE_LEN;

        assign fade_in_rom[gi] = GAIN_W'(GC);
        assign fade_out_rom[gi] = GAIN_W'(FO);
    end

    // Per-channel state.
    logic [IDX_W-1:0] wr_idx_reg [NCH];
    logic             full_reg [NCH];
    logic             playing_reg [NCH];
    logic [IDX_W-1:0] origin_reg [NCH];
    logic [IDX_W-1:0] size_reg [NCH];
    logic [IDX_W-1:0] offset_reg [NCH];
    logic [IDX_W-1:0] rec_cnt_reg [NCH];
    logic [2:0]       pass_reg [NCH];
    logic [FI_W-1:0]  fade_reg [NCH];

    logic [IDX_W-1:0] wr_idx_next;
    logic             full_next;
    logic             playing_next;
    logic [IDX_W-1:0] origin_next;
    logic [IDX_W-1:0] size_next;
    logic [IDX_W-1:0] offset_next;
    logic [IDX_W-1:0] rec_cnt_next;
    logic [2:0]       pass_next;
    logic [FI_W-1:0]  fade_next;

    // Stage between the ring read and the queue.
    logic                       s1_vld_reg;
    src_t                       s1_src_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [GAIN_W-1:0]          s1_gain_reg;

    logic                   ch;
    logic                   in_range;
    logic                   ready;
    logic                   acc;
    logic [IDX_W-1:0]       wp;
    logic [IDX_W:0]         wp_inc;
    logic                   wp_wrap;
    logic [IDX_W-1:0]       slen;
    logic [CW-1:0]          fstart;
    logic [CW-1:0]          k;
    logic [IDX_W:0]         rc_inc;
    logic [IDX_W:0]         org_diff;
    logic [IDX_W:0]         rd_sum;
    logic [IDX_W-1:0]       rp;
    logic [IDX_W:0]         off_inc;
    logic [2:0]             pass_inc;
    logic [GAIN_W-1:0]      gain;
    src_t                   src;
    logic [ADDR_W-1:0]      base;
    logic [SAMPLE_W-1:0]    rdata;

    // Admit a transfer only while the queue has room for everything in flight.
    assign ready = (q_level + Q_LEVEL_W'(s1_vld_reg)) < Q_LEVEL_W'(Q_DEPTH);
    assign samples.ready = ready;
    assign acc = samples.valid && ready;
    assign ch = samples.channel;
    assign in_range = 32'(ch) < 32'(CHANNELS);

    // Slice length saturated to the ring and held at two or more, and the fade-out start.
    always_comb
    begin
        if (cfg.slice_length < 16'd2)
        begin
            slen = IDX_W'(2);
        end
        else if (32'(cfg.slice_length) > 32'(SLEN_MAX))
        begin
            slen = IDX_W'(SLEN_MAX);
        end
        else
        begin
            slen = IDX_W'(cfg.slice_length);
        end
        if (CW'(slen) > CW'(XFADE_LEN))
        begin
            fstart = CW'(slen) - CW'(XFADE_LEN);
        end
        else
        begin
            fstart = '0;
        end
    end

    // Ring addressing: write position, slice origin and backward read position.
    always_comb
    begin
        wp = wr_idx_reg[ch];
        wp_inc = {1'b0, wp} + 1'b1;
        wp_wrap = wp_inc == (IDX_W + 1)'(RING_DEPTH);
        org_diff = {1'b0, wp} - {1'b0, slen};
        if (org_diff[IDX_W])
        begin
            org_diff = org_diff + (IDX_W + 1)'(RING_DEPTH);
        end
        rd_sum = {1'b0, origin_reg[ch]}
               + {1'b0, IDX_W'(size_reg[ch] - offset_reg[ch] - 1'b1)};
        if (rd_sum >= (IDX_W + 1)'(RING_DEPTH))
        begin
            rd_sum = rd_sum - (IDX_W + 1)'(RING_DEPTH);
        end
        rp = IDX_W'(rd_sum);
        base = ch ? ADDR_W'(RING_DEPTH) : '0;
    end

    // Next state of the addressed channel, gain and sample source.
    always_comb
    begin
        wr_idx_next = wp_wrap ? '0 : IDX_W'(wp_inc);
        full_next = full_reg[ch] | wp_wrap;
        playing_next = playing_reg[ch];
        origin_next = origin_reg[ch];
        size_next = size_reg[ch];
        offset_next = offset_reg[ch];
        rec_cnt_next = rec_cnt_reg[ch];
        pass_next = pass_reg[ch];
        fade_next = fade_reg[ch];
        gain = UNITY_GAIN;
        src = SRC_INPUT;
        k = '0;
        rc_inc = {1'b0, rec_cnt_reg[ch]} + 1'b1;
        off_inc = {1'b0, offset_reg[ch]} + 1'b1;
        pass_inc = pass_reg[ch] + 3'd1;

        if (!playing_reg[ch])
        begin
            // Recording: pass through, fading out over the end of the slice.
            if (CW'(rec_cnt_reg[ch]) >= fstart)
            begin
                k = CW'(rec_cnt_reg[ch]) - fstart;
                if (k >= CW'(XFADE_LEN))
                begin
                    gain = '0;
                end
                else
                begin
                    gain = fade_out_rom[FA_W'(k)];
                end
            end
            if (rc_inc >= {1'b0, slen})
            begin
                origin_next = IDX_W'(org_diff);
                size_next = slen;
                offset_next = '0;
                pass_next = '0;
                fade_next = '0;
                playing_next = 1'b1;
                rec_cnt_next = '0;
            end
            else
            begin
                rec_cnt_next = IDX_W'(rc_inc);
            end
        end
        else
        begin
            // Playing backward: the current write wins, unwritten entries read as zero.
            if (rp == wp)
            begin
                src = SRC_INPUT;
            end
            else if (!full_reg[ch] && (rp > wp))
            begin
                src = SRC_ZERO;
            end
            else
            begin
                src = SRC_RAM;
            end
            if (fade_reg[ch] < FI_W'(XFADE_LEN))
            begin
                gain = fade_in_rom[FA_W'(fade_reg[ch])];
                fade_next = fade_reg[ch] + 1'b1;
            end
            if (off_inc >= {1'b0, size_reg[ch]})
            begin
                offset_next = '0;
                fade_next = '0;
                pass_next = pass_inc;
                if ((pass_inc >= cfg.repeat_limit) || (pass_inc == 3'd0))
                begin
                    playing_next = 1'b0;
                    rec_cnt_next = '0;
                    fade_next = FI_W'(XFADE_LEN);
                end
            end
            else
            begin
                offset_next = IDX_W'(off_inc);
            end
        end

        if (!in_range)
        begin
            gain = UNITY_GAIN;
            src = SRC_INPUT;
        end
    end

    // Per-channel state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                wr_idx_reg[i] <= '0;
                full_reg[i] <= 1'b0;
                playing_reg[i] <= 1'b0;
                origin_reg[i] <= '0;
                size_reg[i] <= '0;
                offset_reg[i] <= '0;
                rec_cnt_reg[i] <= '0;
                pass_reg[i] <= '0;
                fade_reg[i] <= FI_W'(XFADE_LEN);
            end
        end
        else if (acc && in_range)
        begin
            wr_idx_reg[ch] <= wr_idx_next;
            full_reg[ch] <= full_next;
            playing_reg[ch] <= playing_next;
            origin_reg[ch] <= origin_next;
            size_reg[ch] <= size_next;
            offset_reg[ch] <= offset_next;
            rec_cnt_reg[ch] <= rec_cnt_next;
            pass_reg[ch] <= pass_next;
            fade_reg[ch] <= fade_next;
        end
    end

    // Sample ring for all channels.
    rsr_ram
    #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NCH * RING_DEPTH)
    )
    u_ring
    (
        .clk   (clk),
        .we    (acc && in_range),
        .waddr (base + ADDR_W'(wp)),
        .wdata (samples.sample_in),
        .re    (acc && in_range && playing_reg[ch]),
        .raddr (base + ADDR_W'(rp)),
        .rdata (rdata)
    );

    // Stage register that lines up with the ring read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_src_reg <= src;
            s1_sample_reg <= samples.sample_in;
            s1_gain_reg <= gain;
        end
    end

    // Queue entry.
    always_comb
    begin
        q_push = s1_vld_reg;
        q_entry.gain = s1_gain_reg;
        case (s1_src_reg)
            SRC_RAM:  q_entry.value = $signed(rdata);
            SRC_ZERO: q_entry.value = '0;
            default:  q_entry.value = s1_sample_reg;
        endcase
    end

    // Playback on channel 0 never reads past the slice.
    a_offset_in_slice: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg[0] |-> (offset_reg[0] < size_reg[0]))
        else $error("play offset beyond slice size");

    // A slice being played on channel 0 always holds at least two samples.
    a_slice_size: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg[0] |-> (size_reg[0] >= IDX_W'(2)))
        else $error("slice too short while playing");

    // A finished recording switches channel 0 to playback with a fresh fade-in.
    a_enter_play: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_range && (ch == 1'b0) && !playing_reg[0] && (rc_inc >= {1'b0, slen}))
        |=> (playing_reg[0] && (fade_reg[0] == '0) && (offset_reg[0] == '0)))
        else $error("recording end did not start playback");

endmodule

// ===== src/rsr_fifo.sv =====
// Short queue between the front and the back.
module rsr_fifo
    import rsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  q_entry_t             push_entry,
    input  logic                 pop,
    output logic [Q_LEVEL_W-1:0] level,
    output logic                 head_valid,
    output q_entry_t             head_entry
);

    q_entry_t store_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_LEVEL_W-1:0] level_reg;
    logic [Q_LEVEL_W-1:0] level_next;

    // Fill level follows push and pop.
    always_comb
    begin
        case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign level = level_reg;
    assign head_valid = level_reg != '0;
    assign head_entry = store_reg[rd_ptr_reg];

    // The front's admission must never overfill the queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((level_reg < Q_LEVEL_W'(Q_DEPTH)) || pop))
        else $error("queue overflow");

    // The back only takes entries that are there.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (level_reg != '0))
        else $error("queue underflow");

endmodule

// ===== src/rsr_back.sv =====
// Back part: applies the gain, rounds and saturates, and holds the result for transfer.
module rsr_back
    import rsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    input  q_entry_t head_entry,
    output logic     pop,
    rsr_out_if.source results
);

    logic                       out_vld_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic signed [SAMPLE_W-1:0] out_data_next;
    logic signed [32:0]         prod;
    logic signed [32:0]         rounded;
    logic signed [17:0]         scaled;

    assign pop = head_valid && (!out_vld_reg || results.ready);

    // Gain product, rounded to nearest and saturated to Q1.15.
    always_comb
    begin
        prod = head_entry.value * $signed({1'b0, head_entry.gain});
        rounded = prod + 33'sd16384;
        scaled = rounded[32:15];
        if (scaled > 18'sd32767)
        begin
            out_data_next = 16'sh7FFF;
        end
        else if (scaled < -18'sd32768)
        begin
            out_data_next = -16'sh8000;
        end
        else
        begin
            out_data_next = scaled[15:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign results.valid = out_vld_reg;
    assign results.sample_out = out_data_reg;

endmodule
